// File: hdl/wast_pkg.sv
// shared constants, types and command codes for the windowed average slew tracker
// no dependencies; every other file of the block imports this package
package wast_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT_W     = 16;
  localparam int SLEW_DIV    = 6;

  // running sum and fill count widths
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  // divide by WINDOW: magnitude times a rounded-up reciprocal, then shift
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam longint unsigned AVG_MUL_L = ((64'd1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(AVG_MUL_L);

  // divide by SLEW_DIV, same scheme on the difference magnitude
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int SLEW_SHIFT = DIFF_W + $clog2(SLEW_DIV);
  localparam int SLEW_MUL_W = DIFF_W + 1;
  localparam int STEP_Q_W   = DIFF_W - $clog2(SLEW_DIV) + 1;
  localparam longint unsigned SLEW_MUL_L =
    ((64'd1 << SLEW_SHIFT) + SLEW_DIV - 1) / SLEW_DIV;
  localparam logic [SLEW_MUL_W-1:0] SLEW_MUL = SLEW_MUL_W'(SLEW_MUL_L);

  // register port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT = REG_IDX_W'(0);
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = LIMIT_W'(6554);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic push;
    logic clear;
  } win_cmd_t;

  typedef struct packed {
    logic upd;
    logic load;
  } trk_ctl_t;

endpackage

// File: hdl/wast_cell.sv
// one window cell: holds an x/z sample pair and hands it on at each push
// depends on wast_pkg
module wast_cell (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] in_x,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] in_z,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] out_x,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] out_z
);
  import wast_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= in_x;
      out_z <= in_z;
    end
  end

endmodule

// File: hdl/wast_window.sv
// sample window: chain of cells, fill count and running sums for both channels
// depends on wast_pkg and wast_cell
module wast_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wast_pkg::win_cmd_t                   cmd,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_z,
  output logic signed [wast_pkg::SUM_W-1:0]       sum_x,
  output logic signed [wast_pkg::SUM_W-1:0]       sum_z,
  output logic                                 full_after
);
  import wast_pkg::*;

  logic signed [SAMPLE_BITS-1:0] tap_x [WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] tap_z [WINDOW+1];
  logic [FILL_W-1:0]             fill_count;
  logic                          full_now;
  logic signed [SAMPLE_BITS-1:0] drop_x;
  logic signed [SAMPLE_BITS-1:0] drop_z;
  logic signed [SUM_W-1:0]       sum_x_next;
  logic signed [SUM_W-1:0]       sum_z_next;

  assign tap_x[0] = sample_x;
  assign tap_z[0] = sample_z;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    wast_cell u_cell (
      .clk   (clk),
      .en    (cmd.push),
      .in_x  (tap_x[i]),
      .in_z  (tap_z[i]),
      .out_x (tap_x[i+1]),
      .out_z (tap_z[i+1])
    );
  end

  assign full_now   = (fill_count == FILL_W'(WINDOW));
  assign full_after = full_now || (fill_count == FILL_W'(WINDOW - 1));

  // last cell is the oldest sample once the window is full
  assign drop_x = full_now ? tap_x[WINDOW] : '0;
  assign drop_z = full_now ? tap_z[WINDOW] : '0;

  assign sum_x_next = sum_x + SUM_W'(sample_x) - SUM_W'(drop_x);
  assign sum_z_next = sum_z + SUM_W'(sample_z) - SUM_W'(drop_z);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill_count <= '0;
      sum_x      <= '0;
      sum_z      <= '0;
    end else if (cmd.push) begin
      if (!full_now) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      sum_x <= sum_x_next;
      sum_z <= sum_z_next;
    end
  end

endmodule

// File: hdl/wast_avg.sv
// window average: signed sum divided by WINDOW, truncated toward zero, registered
// depends on wast_pkg
module wast_avg (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [wast_pkg::SUM_W-1:0]       sum,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] avg
);
  import wast_pkg::*;

  localparam int PROD_W = SUM_W + AVG_MUL_W;

  logic                   neg;
  logic [SUM_W-1:0]       mag;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] quo;

  assign neg  = sum[SUM_W-1];
  assign mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod = PROD_W'(mag) * PROD_W'(AVG_MUL);
  assign quo  = prod[AVG_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      avg <= neg ? signed'(-quo) : signed'(quo);
    end
  end

endmodule

// File: hdl/wast_slew.sv
// slew-limited tracker for one channel: moves toward the average by a clamped sixth
// depends on wast_pkg
module wast_slew (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  wast_pkg::trk_ctl_t                   ctl,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] load_val,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] avg,
  input  logic [wast_pkg::LIMIT_W-1:0]            step_limit,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] tracked
);
  import wast_pkg::*;

  localparam int PROD_W = DIFF_W + SLEW_MUL_W;
  localparam int TOT_W  = SAMPLE_BITS + 2;

  logic signed [DIFF_W-1:0]      diff;
  logic                          neg;
  logic [DIFF_W-1:0]             mag;
  logic [PROD_W-1:0]             prod;
  logic [DIFF_W-1:0]             quo;
  logic [DIFF_W-1:0]             lim;
  logic [DIFF_W-1:0]             step_mag;
  logic signed [DIFF_W-1:0]      step;
  logic signed [TOT_W-1:0]       total;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign diff = DIFF_W'(avg) - DIFF_W'(tracked);
  assign neg  = diff[DIFF_W-1];
  assign mag  = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod = PROD_W'(mag) * PROD_W'(SLEW_MUL);
  assign quo  = DIFF_W'(prod[SLEW_SHIFT +: STEP_Q_W]);
  assign lim  = DIFF_W'(step_limit);

  // clamp the magnitude, then restore the sign (truncation toward zero)
  assign step_mag = (quo > lim) ? lim : quo;
  assign step     = neg ? signed'(-step_mag) : signed'(step_mag);
  assign total    = TOT_W'(tracked) + TOT_W'(step);

  always_comb begin
    if (total[TOT_W-1:SAMPLE_BITS-1] == '0 || total[TOT_W-1:SAMPLE_BITS-1] == '1) begin
      sat = total[SAMPLE_BITS-1:0];
    end else if (total[TOT_W-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked <= '0;
    end else if (en) begin
      if (ctl.load) begin
        tracked <= load_val;
      end else if (ctl.upd) begin
        tracked <= sat;
      end
    end
  end

endmodule

// File: hdl/windowed_average_slew_tracker_unit.sv
// top level of the windowed average slew tracker: input stage, averaging stage, tracker
// depends on wast_pkg, wast_window, wast_avg and wast_slew
//
// usage
//   input channel: in_valid/in_ready carry one transaction of kind, sample_x, sample_z.
//     kind push shifts the x/z pair into a window of the last WINDOW samples; clear
//     empties the window; load sets the tracked offsets; the fourth code changes nothing.
//   output channel: out_valid/out_ready carry exactly one transaction per input
//     transaction, in order: offset_x, offset_z after that item and window_full, which
//     is 1 only for a push that leaves the window full and so moved the offsets.
//   register port: APB-style, step_limit at byte address 0 (Q0.16 step clamp).
//     Write it only while the block is idle.
//   pipeline: three stages (window and running sums, then division by WINDOW, then the
//     tracker update), each registered; a result is shown once it leaves the last one.
//   throughput: one transaction per cycle unless stalled. The tracker recurrence
//     (difference, divide by six, clamp, add, saturate) closes within the last stage.
//   stall: each stage holds its item while the next one is stuck; with out_ready low,
//     two more transactions fill the empty stages, then in_ready drops until it returns
//   reset: synchronous, clears the window, sums, offsets and all stage valid bits;
//     step_limit returns to its default of about 0.1.
module windowed_average_slew_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // input transactions
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_z,
  // output transactions
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_x,
  output logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_z,
  output logic                                 window_full,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wast_pkg::ADDR_W-1:0]             paddr,
  input  logic [wast_pkg::DATA_W-1:0]             pwdata,
  output logic [wast_pkg::DATA_W-1:0]             prdata,
  output logic                                 pready
);
  import wast_pkg::*;

  // register port
  logic [LIMIT_W-1:0]   step_limit;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  // stage flow control
  logic accept;
  logic a_valid, a_move, a_free;
  logic b_valid, b_move, b_free;
  logic c_free;

  // input decode
  win_cmd_t cmd;
  trk_ctl_t in_ctl;
  logic     full_after;

  // stage a: item after the window update
  trk_ctl_t                      a_ctl;
  logic signed [SAMPLE_BITS-1:0] a_ldx, a_ldz;
  logic signed [SUM_W-1:0]       sum_x, sum_z;

  // stage b: item with its averages
  trk_ctl_t                      b_ctl;
  logic signed [SAMPLE_BITS-1:0] b_ldx, b_ldz;
  logic signed [SAMPLE_BITS-1:0] avg_x, avg_z;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_STEP_LIMIT: prdata = DATA_W'(step_limit);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= STEP_LIMIT_RESET;
    end else if (reg_wr && reg_idx == REG_STEP_LIMIT) begin
      step_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flow control
  // a stage may take a new item when empty or when its own item leaves this cycle
  assign c_free   = !out_valid || out_ready;
  assign b_move   = b_valid && c_free;
  assign b_free   = !b_valid || c_free;
  assign a_move   = a_valid && b_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------- input decode
  always_comb begin
    cmd    = '0;
    in_ctl = '0;
    unique case (kind)
      KIND_PUSH: begin
        cmd.push   = accept;
        in_ctl.upd = full_after;
      end
      KIND_CLEAR: begin
        cmd.clear = accept;
      end
      KIND_LOAD: begin
        in_ctl.load = 1'b1;
      end
      default: begin
        // unused code: result repeats the current offsets
      end
    endcase
  end

  // ---------------------------------------------------------------- stage a: window
  wast_window u_window (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_x   (sample_x),
    .sample_z   (sample_z),
    .sum_x      (sum_x),
    .sum_z      (sum_z),
    .full_after (full_after)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctl <= in_ctl;
      a_ldx <= sample_x;
      a_ldz <= sample_z;
    end
  end

  // ---------------------------------------------------------------- stage b: averages
  // the running sums still belong to the item in stage a when it moves on
  wast_avg u_avg_x (
    .clk (clk),
    .en  (a_move),
    .sum (sum_x),
    .avg (avg_x)
  );

  wast_avg u_avg_z (
    .clk (clk),
    .en  (a_move),
    .sum (sum_z),
    .avg (avg_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_move;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_ctl <= a_ctl;
      b_ldx <= a_ldx;
      b_ldz <= a_ldz;
    end
  end

  // ---------------------------------------------------------------- stage c: trackers
  // the tracked offsets are the output register
  wast_slew u_slew_x (
    .clk        (clk),
    .rst        (rst),
    .en         (b_move),
    .ctl        (b_ctl),
    .load_val   (b_ldx),
    .avg        (avg_x),
    .step_limit (step_limit),
    .tracked    (offset_x)
  );

  wast_slew u_slew_z (
    .clk        (clk),
    .rst        (rst),
    .en         (b_move),
    .ctl        (b_ctl),
    .load_val   (b_ldz),
    .avg        (avg_z),
    .step_limit (step_limit),
    .tracked    (offset_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_free) begin
      out_valid <= b_move;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      window_full <= b_ctl.upd;
    end
  end

endmodule

// File: hdl/wast_chk.sv
// port-level checker for the windowed average slew tracker, bound to the top level
// depends on wast_pkg and windowed_average_slew_tracker_unit
module wast_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [1:0]                           kind,
  input logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_x,
  input logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_z,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_x,
  input logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_z,
  input logic                                 window_full
);
  import wast_pkg::*;

  // no result survives reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(offset_x) && $stable(offset_z)
      && $stable(window_full))
    else $error("stalled result changed");

  // an empty output means every stage can move
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a load with no stall shows its offsets on the output with window_full low
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LOAD && out_ready ##1 out_ready ##1 out_ready
      |=> out_valid && !window_full && offset_x == $past(sample_x, 3)
        && offset_z == $past(sample_z, 3))
    else $error("load transaction not reflected on the output");

endmodule

bind windowed_average_slew_tracker_unit wast_chk u_wast_chk (.*);

// File: dv/wast_offset_checker.sv
`timescale 1ns / 100ps
// result checker for the windowed average slew tracker: tracks window, sums and offsets,
// predicts every result and compares it; depends on wast_pkg
module wast_offset_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic [1:0]                              kind,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] sample_z,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_x,
  input  logic signed [wast_pkg::SAMPLE_BITS-1:0] offset_z,
  input  logic                                    window_full,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [wast_pkg::ADDR_W-1:0]             paddr,
  input  logic [wast_pkg::DATA_W-1:0]             pwdata,
  input  logic                                    pready,
  output int                                      fail_count,
  output int                                      outstanding
);
  import wast_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] off_x;
    logic signed [SAMPLE_BITS-1:0] off_z;
    logic                          full;
  } offsets_t;

  logic signed [SAMPLE_BITS-1:0] hist_x [WINDOW];
  logic signed [SAMPLE_BITS-1:0] hist_z [WINDOW];
  logic signed [SUM_W-1:0]       sum_x, sum_z;
  logic signed [SAMPLE_BITS-1:0] trk_x, trk_z;
  logic [LIMIT_W-1:0]            step_limit;
  int                            held, slot;
  offsets_t                      due_offsets [$];

  function automatic void empty_window();
    foreach (hist_x[i]) begin
      hist_x[i] = '0;
      hist_z[i] = '0;
    end
    held  = 0;
    slot  = 0;
    sum_x = '0;
    sum_z = '0;
  endfunction

  // one slew-limited move of an offset toward the window mean
  function automatic logic signed [SAMPLE_BITS-1:0] chase(
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic signed [SUM_W-1:0]       total
  );
    longint mean, delta, lim, nxt, top_val;
    mean    = longint'(total) / WINDOW;
    delta   = (mean - longint'(cur)) / SLEW_DIV;
    lim     = longint'(step_limit);
    top_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    if (delta > lim) delta = lim;
    if (delta < -lim) delta = -lim;
    nxt = longint'(cur) + delta;
    if (nxt > top_val) nxt = top_val;
    if (nxt < -top_val - 1) nxt = -top_val - 1;
    return nxt[SAMPLE_BITS-1:0];
  endfunction

  function automatic offsets_t track_item(
    input logic [1:0]                    code,
    input logic signed [SAMPLE_BITS-1:0] sx,
    input logic signed [SAMPLE_BITS-1:0] sz
  );
    offsets_t res;
    res.full = 1'b0;
    case (code)
      KIND_PUSH: begin
        // a full window drops its oldest sample from the sums
        if (held == WINDOW) begin
          sum_x -= hist_x[slot];
          sum_z -= hist_z[slot];
        end else begin
          held++;
        end
        hist_x[slot] = sx;
        hist_z[slot] = sz;
        sum_x += sx;
        sum_z += sz;
        slot = (slot == WINDOW - 1) ? 0 : slot + 1;
        if (held == WINDOW) begin
          trk_x = chase(trk_x, sum_x);
          trk_z = chase(trk_z, sum_z);
          res.full = 1'b1;
        end
      end
      KIND_CLEAR: empty_window();
      KIND_LOAD: begin
        trk_x = sx;
        trk_z = sz;
      end
      default: ;
    endcase
    res.off_x = trk_x;
    res.off_z = trk_z;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    offsets_t want;
    if (rst) begin
      empty_window();
      trk_x      = '0;
      trk_z      = '0;
      step_limit = STEP_LIMIT_RESET;
      fail_count = 0;
      due_offsets.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_STEP_LIMIT)
        step_limit = pwdata[LIMIT_W-1:0];
      if (in_valid && in_ready)
        due_offsets.insert(due_offsets.size(), track_item(kind, sample_x, sample_z));
      if (out_valid && out_ready) begin
        if (due_offsets.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0d %0d %0d",
                   $time, offset_x, offset_z, window_full);
          fail_count++;
        end else begin
          want = due_offsets[0];
          due_offsets.delete(0);
          if (offset_x !== want.off_x) begin
            $display("%0t offset_x: expected %0d actual %0d", $time, want.off_x, offset_x);
            fail_count++;
          end
          if (offset_z !== want.off_z) begin
            $display("%0t offset_z: expected %0d actual %0d", $time, want.off_z, offset_z);
            fail_count++;
          end
          if (window_full !== want.full) begin
            $display("%0t window_full: expected %0d actual %0d", $time, want.full,
                     window_full);
            fail_count++;
          end
        end
      end
    end
    outstanding = due_offsets.size();
  end

endmodule

// File: dv/windowed_average_slew_tracker_unit_test.sv
`timescale 1ns / 100ps
// testbench top for windowed_average_slew_tracker_unit: clock, reset, stimulus, verdict
// depends on wast_pkg, the block and wast_offset_checker
module windowed_average_slew_tracker_unit_test;
  import wast_pkg::*;

  // kind code that the block must ignore, and a register index with nothing behind it
  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE   = REG_IDX_W'(1);
  localparam int                   PHASES      = 5;
  localparam int                   PHASE_ITEMS = 130;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    kind = KIND_PUSH;
  logic signed [SAMPLE_BITS-1:0] sample_x = '0;
  logic signed [SAMPLE_BITS-1:0] sample_z = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_z;
  logic                          window_full;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  int                            fail_count;
  int                            outstanding;
  // when set, neither side inserts gaps or stalls
  bit                            no_idle = 1'b0;

  windowed_average_slew_tracker_unit dut (.*);

  wast_offset_checker checker_i (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: after each accepted transaction, optionally hold out_ready low for a while
  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        hold = no_idle ? 0 : $urandom_range(0, 5);
        if (hold != 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end
    end
  end

  // one input transaction; valid stays high across back-to-back items
  task automatic send_item(
    input logic [1:0]                    code,
    input logic signed [SAMPLE_BITS-1:0] sx,
    input logic signed [SAMPLE_BITS-1:0] sz
  );
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= code;
    sample_x <= sx;
    sample_z <= sz;
    do @(posedge clk); while (!in_ready);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  // sample value: mostly near a center so steps fall inside the clamp, some full range,
  // some at the field extremes, zero or minus one
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
    input logic signed [SAMPLE_BITS-1:0] center
  );
    logic signed [SAMPLE_BITS-1:0] val;
    int                            dev;
    dev = int'($urandom_range(0, 20000)) - 10000;
    case ($urandom_range(0, 5))
      0, 1: val = SAMPLE_BITS'($urandom());
      2: begin
        case ($urandom_range(0, 3))
          0:       val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          1:       val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          2:       val = '0;
          default: val = '1;
        endcase
      end
      default: val = center + SAMPLE_BITS'(dev);
    endcase
    return val;
  endfunction

  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] s_max, s_min, center;
    logic [LIMIT_W-1:0]            limits [PHASES];
    int unsigned                   roll;

    s_max = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    s_min = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    limits[0] = '0;
    limits[1] = '1;
    limits[2] = LIMIT_W'($urandom());
    limits[3] = LIMIT_W'(1);
    limits[4] = STEP_LIMIT_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, default step limit
    // offsets loaded to opposite extremes, then a window of the other extremes
    send_item(KIND_LOAD, s_max, s_min);
    repeat (WINDOW) send_item(KIND_PUSH, s_min, s_max);
    // push into a full window overwrites the oldest sample
    send_item(KIND_PUSH, s_max, s_min);
    // unused code leaves everything alone
    send_item(KIND_UNUSED, 24'sh5A5A5A, '1);
    // clear keeps the offsets
    send_item(KIND_CLEAR, '0, '0);
    send_item(KIND_LOAD, 24'sd1, -24'sd1);
    send_item(KIND_PUSH, -24'sd1, 24'sd1);

    // random phases, each with its own step limit and sample center
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(REG_STEP_LIMIT, DATA_W'(limits[p]));
      // writes to an index past step_limit must have no effect
      if (p == 2) write_reg(REG_SPARE, $urandom());
      center = SAMPLE_BITS'(int'($urandom_range(0, 8000000)) - 4000000);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches with no gaps on either side
        if (n % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
        roll = $urandom_range(0, 99);
        // mostly pushes so the window keeps filling; clears are rare enough
        // that full windows and wraparound happen often
        if (roll < 84)
          send_item(KIND_PUSH, pick_sample(center), pick_sample(center));
        else if (roll < 90)
          send_item(KIND_LOAD, pick_sample(center), pick_sample(center));
        else if (roll < 95)
          send_item(KIND_CLEAR, pick_sample(center), pick_sample(center));
        else
          send_item(KIND_UNUSED, pick_sample(center), pick_sample(center));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: windowed_average_slew_tracker_unit.f
hdl/wast_pkg.sv
hdl/wast_cell.sv
hdl/wast_window.sv
hdl/wast_avg.sv
hdl/wast_slew.sv
hdl/windowed_average_slew_tracker_unit.sv
hdl/wast_chk.sv
dv/wast_offset_checker.sv
dv/windowed_average_slew_tracker_unit_test.sv
